[rtl/core/sfrq_pkg.sv]
// types, codes and constants shared by the sorted floor request queue
`timescale 1ns / 1ps
`default_nettype none

package sfrq_pkg;

    // one held request: floor key and two companion words
    typedef struct packed {
        logic [7:0]        floor_num;
        logic signed [8:0] info_a;
        logic signed [8:0] info_b;
    } entry_t;

    // operation codes carried in the input tuser
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // what an empty queue reports for front and back
    localparam entry_t ENTRY_EMPTY = '{floor_num: 8'd0, info_a: -9'sd1, info_b: -9'sd1};

    // stream and register port widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map
    localparam logic [APB_ADDR_W-1:0] ADDR_ORDER = 3'd0;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_COMPARE = 4'b0010,
        ST_UPDATE  = 4'b0100,
        ST_RESULT  = 4'b1000
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/sfrq_ctrl.sv]
// controller state machine: stream handshakes and datapath sequencing
`timescale 1ns / 1ps
`default_nettype none

module sfrq_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output sfrq_pkg::cmd_t   cmd
);
    import sfrq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // handshakes and commands
    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        m_tvalid     = out_valid_reg;
        cmd.capture  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.compare  = (state_reg == ST_COMPARE);
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.load_out = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (cmd.load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output transaction holds until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sfrq_datapath.sv]
// datapath: row of compare-and-shift cells, count, back entry and result register
`timescale 1ns / 1ps
`default_nettype none

module sfrq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sfrq_pkg::cmd_t                  cmd,
    input  wire logic                            descending,
    // s_tdata: floor_key[7:0], info_a[16:8], info_b[25:17], zero fill
    input  wire logic [sfrq_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [sfrq_pkg::IN_USER_W-1:0]  s_tuser,
    // m_tdata: entry_count[4:0], is_empty[5], front_floor[13:6], front_info_a[22:14],
    // front_info_b[31:23], back_floor[39:32], back_info_a[48:40], back_info_b[57:49],
    // accepted[58], dropped_full[59], zero fill
    output logic [sfrq_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import sfrq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [1:0]              op_reg;
    entry_t                  item_reg;
    entry_t                  cell_reg [CAPACITY];
    entry_t                  cell_next [CAPACITY];
    entry_t                  back_reg;
    entry_t                  back_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CAPACITY-1:0]     before_reg;
    logic [CAPACITY-1:0]     before_next;
    logic [CAPACITY-1:0]     match_reg;
    logic [CAPACITY-1:0]     match_next;
    logic                    acc_reg;
    logic                    drop_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;

    logic                    any_before;
    logic                    is_dup;
    logic                    is_full;
    logic                    do_insert;
    logic                    is_empty;
    entry_t                  front_ent;
    entry_t                  back_ent;
    logic [CW+4:0]           count_ext;

    // capture of the incoming transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg             <= s_tuser[1:0];
            item_reg.floor_num <= s_tdata[7:0];
            item_reg.info_a    <= s_tdata[16:8];
            item_reg.info_b    <= s_tdata[25:17];
        end
    end

    // per-cell compare against the new key, only held cells count
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CW'(i) < count_reg)
            begin
                match_next[i]  = (cell_reg[i].floor_num == item_reg.floor_num);
                before_next[i] = descending ? (item_reg.floor_num > cell_reg[i].floor_num)
                                            : (item_reg.floor_num < cell_reg[i].floor_num);
            end
            else
            begin
                match_next[i]  = 1'b0;
                before_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            before_reg <= before_next;
            match_reg  <= match_next;
        end
    end

    // insert decision
    assign any_before = |before_reg;
    assign is_dup     = |match_reg;
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign do_insert  = (op_reg == OP_INSERT) && !is_dup && !is_full;

    // cell update: shift toward the back behind the insert slot, or toward the front on remove
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [CAPACITY-1:0] lower_mask;
        logic                behind_slot;
        entry_t              from_prev;
        entry_t              from_next;

        assign lower_mask  = ~({CAPACITY{1'b1}} << g);
        assign behind_slot = |(before_reg & lower_mask);

        if (g == 0)
        begin : g_first
            assign from_prev = cell_reg[0];
        end
        else
        begin : g_rest
            assign from_prev = cell_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign from_next = cell_reg[g];
        end
        else
        begin : g_inner
            assign from_next = cell_reg[g+1];
        end

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (do_insert)
            begin
                if (behind_slot)
                begin
                    cell_next[g] = from_prev;
                end
                else if (before_reg[g] || (!any_before && (CW'(g) == count_reg)))
                begin
                    cell_next[g] = item_reg;
                end
            end
            else if ((op_reg == OP_REMOVE) && (count_reg != '0))
            begin
                cell_next[g] = from_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.update)
            begin
                cell_reg[g] <= cell_next[g];
            end
        end
    end

    // count and back entry
    always_comb
    begin
        count_next = count_reg;
        back_next  = back_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (do_insert)
                begin
                    count_next = count_reg + 1'b1;
                    if (!any_before)
                    begin
                        back_next = item_reg;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            back_reg <= back_next;
            acc_reg  <= do_insert;
            drop_reg <= (op_reg == OP_INSERT) && !is_dup && is_full;
        end
    end

    // result register
    assign is_empty  = (count_reg == '0);
    assign front_ent = is_empty ? ENTRY_EMPTY : cell_reg[0];
    assign back_ent  = is_empty ? ENTRY_EMPTY : back_reg;
    assign count_ext = {5'b00000, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= {4'b0000, drop_reg, acc_reg,
                            back_ent.info_b, back_ent.info_a, back_ent.floor_num,
                            front_ent.info_b, front_ent.info_a, front_ent.floor_num,
                            is_empty, count_ext[4:0]};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

[rtl/core/sorted_floor_request_queue.sv]
// Sorted floor request queue, top level.
// Keeps up to CAPACITY floor requests sorted by floor, ascending or descending,
// with a floor already held never added twice.
// Input stream: s_tuser carries the operation (insert, remove front, clear all),
// s_tdata the floor key and the two info words. Every input transaction gives
// exactly one output transaction on m_tdata: count, empty flag, front and back
// entries (floor 0, info -1, -1 when empty), accepted and dropped-full flags.
// The result is registered after the input is taken, through the compare,
// update and result steps; a new item is taken only after the result step, as
// the capture, compare, update and result steps of the controller share the cell row.
// The result register parts the two sides: a new item is taken while the
// previous result waits; if the receiver stalls, the next result waits in the
// result step and input is held off until the output register frees.
// Reset clears the count and the order register (ascending); held entries need
// no clearing. The order register sits at byte address 0 of the APB port; it is
// to be written only while the queue is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module sorted_floor_request_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: floor_key[7:0], info_a[16:8], info_b[25:17], zero fill
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [sfrq_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [sfrq_pkg::IN_USER_W-1:0]   s_tuser,
    // m_tdata: entry_count[4:0], is_empty[5], front_floor[13:6], front_info_a[22:14],
    // front_info_b[31:23], back_floor[39:32], back_info_a[48:40], back_info_b[57:49],
    // accepted[58], dropped_full[59], zero fill
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sfrq_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sfrq_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sfrq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfrq_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import sfrq_pkg::*;

    cmd_t cmd;
    logic order_reg;
    logic cfg_write;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_write && (paddr == ADDR_ORDER))
        begin
            order_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_ORDER)
        begin
            prdata[0] = order_reg;
        end
    end

    // controller
    sfrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath
    sfrq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .descending (order_reg),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tdata    (m_tdata)
    );

    // an accepted transaction keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while an item is in progress");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("result loaded but not presented");

    // an insert is never both taken and dropped
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[58] && m_tdata[59]))
        else $error("accepted and dropped_full both set");

endmodule

`default_nettype wire
